>>> rtl/indexed_binary_heap_queue_macros.svh
// Assertion helpers for the top-level queue module.
`ifndef INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH
`define INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IBHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define IBHQ_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/ibhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ibhq_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int ID_W     = 7;
  localparam int CNT_W    = 7;
  localparam int PRI_W    = 32;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_CHANGE = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_PEEK   = 3'd4,
    ACT_GET    = 3'd5
  } act_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_FAIL, OP_INSERT, OP_RD_POS, OP_RD_TOP, OP_CHANGE,
    OP_RD_GET, OP_GET_DONE, OP_REMOVE, OP_PEEK_DONE, OP_DEL_TOP, OP_TAKE,
    OP_UP_RD, OP_UP_MOVE, OP_DN_RD, OP_DN_MOVE, OP_PLACE, OP_OUT
  } op_e;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
  } heap_ent_t;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       insert_ok;
    logic       present;
    logic       nonempty;
    logic       s_is_top;
    logic       moved;
    logic       up_better;
    logic       dn_end;
    logic       dn_better;
    logic       s_lt_cnt;
    logic       out_free;
  } status_t;

  function automatic logic better(input logic signed [PRI_W-1:0] a,
                                  input logic signed [PRI_W-1:0] b,
                                  input logic min_first);
    return min_first ? (a < b) : (a > b);
  endfunction

endpackage
`default_nettype wire

>>> rtl/ibhq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ibhq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ibhq_pkg::status_t status_i,
  output ibhq_pkg::cmd_t   cmd_o
);
  import ibhq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DECODE   = 12'b000000000010,
    S_LOOKUP   = 12'b000000000100,
    S_GETWAIT  = 12'b000000001000,
    S_TOPWAIT  = 12'b000000010000,
    S_LASTWAIT = 12'b000000100000,
    S_UP_RD    = 12'b000001000000,
    S_UP_CMP   = 12'b000010000000,
    S_DN_RD    = 12'b000100000000,
    S_DN_CMP   = 12'b001000000000,
    S_PLACE    = 12'b010000000000,
    S_FINISH   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.act)
          ACT_INSERT: begin
            op      = status_i.insert_ok ? OP_INSERT : OP_FAIL;
            state_d = status_i.insert_ok ? S_UP_RD : S_FINISH;
          end
          ACT_CHANGE, ACT_REMOVE, ACT_GET: begin
            op      = status_i.present ? OP_RD_POS : OP_FAIL;
            state_d = status_i.present ? S_LOOKUP : S_FINISH;
          end
          ACT_DELETE, ACT_PEEK: begin
            op      = status_i.nonempty ? OP_RD_TOP : OP_FAIL;
            state_d = status_i.nonempty ? S_TOPWAIT : S_FINISH;
          end
          default: begin
            op      = OP_FAIL;
            state_d = S_FINISH;
          end
        endcase
      end
      S_LOOKUP: begin
        case (status_i.act)
          ACT_CHANGE: begin
            op      = OP_CHANGE;
            state_d = S_UP_RD;
          end
          ACT_GET: begin
            op      = OP_RD_GET;
            state_d = S_GETWAIT;
          end
          default: begin
            op      = OP_REMOVE;
            state_d = S_LASTWAIT;
          end
        endcase
      end
      S_GETWAIT: begin
        op      = OP_GET_DONE;
        state_d = S_FINISH;
      end
      S_TOPWAIT: begin
        if (status_i.act == ACT_PEEK) begin
          op      = OP_PEEK_DONE;
          state_d = S_FINISH;
        end else begin
          op      = OP_DEL_TOP;
          state_d = S_LASTWAIT;
        end
      end
      S_LASTWAIT: begin
        op      = OP_TAKE;
        state_d = status_i.s_lt_cnt ? S_UP_RD : S_FINISH;
      end
      S_UP_RD: begin
        if (status_i.s_is_top) begin
          state_d = status_i.moved ? S_PLACE : S_DN_RD;
        end else begin
          op      = OP_UP_RD;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status_i.up_better) begin
          op      = OP_UP_MOVE;
          state_d = S_UP_RD;
        end else begin
          state_d = status_i.moved ? S_PLACE : S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (status_i.dn_end) begin
          state_d = S_PLACE;
        end else begin
          op      = OP_DN_RD;
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status_i.dn_better) begin
          op      = OP_DN_MOVE;
          state_d = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        op      = OP_PLACE;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (status_i.out_free) begin
          op      = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;

endmodule
`default_nettype wire

>>> rtl/ibhq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ibhq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [2:0]                        action_i,
  input  logic [ibhq_pkg::ID_W-1:0]         item_id_i,
  input  logic signed [ibhq_pkg::PRI_W-1:0] item_priority_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [ibhq_pkg::CNT_W-1:0]        cfg_data_i,
  input  ibhq_pkg::cmd_t                    cmd_i,
  output ibhq_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ok_o,
  output logic [ibhq_pkg::ID_W-1:0]         out_id_o,
  output logic signed [ibhq_pkg::PRI_W-1:0] out_priority_o,
  output logic [ibhq_pkg::CNT_W-1:0]        count_o
);
  import ibhq_pkg::*;

  heap_ent_t         heap_mem [CAPACITY];
  logic [SLOT_W-1:0] pos_mem  [CAPACITY+1];

  heap_ent_t         heap_a_q, heap_b_q;
  logic [SLOT_W-1:0] pos_q;

  logic [2:0]              req_act_q;
  logic [ID_W-1:0]         req_id_q, rm_id_q;
  logic signed [PRI_W-1:0] req_pri_q;
  heap_ent_t               cur_q;
  logic [CNT_W-1:0]        s_q;
  logic                    moved_q;
  logic                    res_ok_q;
  logic [ID_W-1:0]         res_id_q;
  logic signed [PRI_W-1:0] res_pri_q;

  logic [CAPACITY:0]  present_q;
  logic [CNT_W-1:0]   count_q;
  logic               min_order_q;
  logic [CNT_W-1:0]   cap_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [ID_W-1:0]    out_id_q;
  logic signed [PRI_W-1:0] out_pri_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic              heap_we, rd_a, rd_b, pos_we, rd_pos;
  logic [SLOT_W-1:0] heap_wa, ra_a, ra_b;
  heap_ent_t         heap_wd;
  logic [CNT_W-1:0]  pos_wa, ra_pos;
  logic [SLOT_W-1:0] pos_wd;

  logic             valid_id, present, sel_r, has_r;
  logic [CNT_W-1:0] limit, cslot;
  logic [CNT_W:0]   l;
  heap_ent_t        child;
  logic [SLOT_W-1:0] s_idx;

  assign valid_id = (req_id_q <= CAP_C);
  assign present  = valid_id && present_q[req_id_q];
  assign limit    = (cap_q < CAP_C) ? cap_q : CAP_C;
  assign l        = {s_q, 1'b0};
  assign has_r    = (l < {1'b0, count_q});
  assign sel_r    = has_r && !better(heap_a_q.pri, heap_b_q.pri, min_order_q);
  assign child    = sel_r ? heap_b_q : heap_a_q;
  assign cslot    = sel_r ? CNT_W'(l + 1'b1) : CNT_W'(l);
  assign s_idx    = SLOT_W'(s_q - 1'b1);

  always_comb begin
    status_o.act       = req_act_q;
    status_o.insert_ok = valid_id && !present_q[req_id_q] && (count_q < limit);
    status_o.present   = present;
    status_o.nonempty  = (count_q != '0);
    status_o.s_is_top  = (s_q == CNT_W'(1));
    status_o.moved     = moved_q;
    status_o.up_better = better(cur_q.pri, heap_a_q.pri, min_order_q);
    status_o.dn_end    = (l > {1'b0, count_q});
    status_o.dn_better = better(child.pri, cur_q.pri, min_order_q);
    status_o.s_lt_cnt  = (s_q < count_q);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // memory port control
  always_comb begin
    heap_we = 1'b0;
    heap_wa = s_idx;
    heap_wd = cur_q;
    pos_we  = 1'b0;
    pos_wa  = cur_q.id;
    pos_wd  = s_idx;
    rd_a    = 1'b0;
    ra_a    = '0;
    rd_b    = 1'b0;
    ra_b    = l[SLOT_W-1:0];
    rd_pos  = 1'b0;
    ra_pos  = req_id_q;
    case (cmd_i.op)
      OP_RD_POS:  rd_pos = 1'b1;
      OP_RD_TOP:  rd_a   = 1'b1;
      OP_RD_GET: begin
        rd_a = 1'b1;
        ra_a = pos_q;
      end
      OP_REMOVE, OP_DEL_TOP: begin
        rd_a = 1'b1;
        ra_a = SLOT_W'(count_q - 1'b1);
      end
      OP_UP_RD: begin
        rd_a = 1'b1;
        ra_a = SLOT_W'((s_q >> 1) - 1'b1);
      end
      OP_DN_RD: begin
        rd_a = 1'b1;
        ra_a = SLOT_W'(l - 1'b1);
        rd_b = 1'b1;
      end
      OP_UP_MOVE: begin
        heap_we = 1'b1;
        heap_wd = heap_a_q;
        pos_we  = 1'b1;
        pos_wa  = heap_a_q.id;
      end
      OP_DN_MOVE: begin
        heap_we = 1'b1;
        heap_wd = child;
        pos_we  = 1'b1;
        pos_wa  = child.id;
      end
      OP_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (rd_a) heap_a_q <= heap_mem[ra_a];
    if (rd_b) heap_b_q <= heap_mem[ra_b];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (rd_pos) pos_q <= pos_mem[ra_pos];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        req_act_q <= action_i;
        req_id_q  <= item_id_i;
        req_pri_q <= item_priority_i;
      end
      OP_FAIL: begin
        res_ok_q  <= 1'b0;
        res_id_q  <= '0;
        res_pri_q <= '0;
      end
      OP_INSERT: begin
        cur_q     <= '{id: req_id_q, pri: req_pri_q};
        s_q       <= count_q + 1'b1;
        moved_q   <= 1'b0;
        res_ok_q  <= 1'b1;
        res_id_q  <= '0;
        res_pri_q <= '0;
      end
      OP_CHANGE: begin
        cur_q     <= '{id: req_id_q, pri: req_pri_q};
        s_q       <= {1'b0, pos_q} + 1'b1;
        moved_q   <= 1'b0;
        res_ok_q  <= 1'b1;
        res_id_q  <= '0;
        res_pri_q <= '0;
      end
      OP_GET_DONE: begin
        res_ok_q  <= 1'b1;
        res_id_q  <= '0;
        res_pri_q <= heap_a_q.pri;
      end
      OP_REMOVE: begin
        s_q       <= {1'b0, pos_q} + 1'b1;
        rm_id_q   <= req_id_q;
        res_ok_q  <= 1'b1;
        res_id_q  <= '0;
        res_pri_q <= '0;
      end
      OP_PEEK_DONE: begin
        res_ok_q  <= 1'b1;
        res_id_q  <= heap_a_q.id;
        res_pri_q <= heap_a_q.pri;
      end
      OP_DEL_TOP: begin
        s_q       <= CNT_W'(1);
        rm_id_q   <= heap_a_q.id;
        res_ok_q  <= 1'b1;
        res_id_q  <= heap_a_q.id;
        res_pri_q <= heap_a_q.pri;
      end
      OP_TAKE: begin
        // last entry fills the hole
        cur_q   <= heap_a_q;
        moved_q <= 1'b0;
      end
      OP_UP_MOVE: begin
        s_q     <= s_q >> 1;
        moved_q <= 1'b1;
      end
      OP_DN_MOVE: s_q <= cslot;
      OP_OUT: begin
        out_ok_q  <= res_ok_q;
        out_id_q  <= res_id_q;
        out_pri_q <= res_pri_q;
        out_cnt_q <= count_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      count_q     <= '0;
      min_order_q <= 1'b1;
      cap_q       <= CAP_C;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) cap_q <= cfg_data_i;
        else           min_order_q <= cfg_data_i[0];
      end
      if (cmd_i.op == OP_INSERT) begin
        count_q             <= count_q + 1'b1;
        present_q[req_id_q] <= 1'b1;
      end else if (cmd_i.op == OP_TAKE) begin
        count_q            <= count_q - 1'b1;
        present_q[rm_id_q] <= 1'b0;
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_pri_q;
  assign count_o        = out_cnt_q;

endmodule
`default_nettype wire

>>> rtl/indexed_binary_heap_queue.sv
// Indexed binary heap priority queue, up to 64 (id, priority) entries.
// Request channel: in_valid_i/in_ready_o with action_i, item_id_i and
// item_priority_i (signed Q16.16). Every request gives exactly one result on
// out_valid_o/out_ready_i: ok_o, out_id_o, out_priority_o and count_o.
// One request is in work at a time; in_ready_o is high only when idle.
// Insert, change, remove and delete top run a sift loop that takes, per heap
// level, one read of the heap RAM and one compare and move, over at most six
// levels; a failed request, a peek and a get run no sift loop.
// The result sits in an output register; a stalled receiver holds it, and
// the next request is accepted meanwhile but does not finish until the
// register is free.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 selects min
// (1) or max (0) order, index 1 sets the capacity limit. Write only idle.
// Reset empties the queue, selects min order and a limit of 64; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_binary_heap_queue_macros.svh"
module indexed_binary_heap_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        action_i,
  input  logic [ibhq_pkg::ID_W-1:0]         item_id_i,
  input  logic signed [ibhq_pkg::PRI_W-1:0] item_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ok_o,
  output logic [ibhq_pkg::ID_W-1:0]         out_id_o,
  output logic signed [ibhq_pkg::PRI_W-1:0] out_priority_o,
  output logic [ibhq_pkg::CNT_W-1:0]        count_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [ibhq_pkg::CNT_W-1:0]        cfg_data_i
);
  import ibhq_pkg::*;

  cmd_t    cmd;
  status_t status;

  ibhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ibhq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .item_id_i       (item_id_i),
    .item_priority_i (item_priority_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .count_o         (count_o)
  );

  `IBHQ_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accept while busy")
  `IBHQ_ASSERT_IMP(a_count_range, out_valid_o, count_o <= CAP_C, "count beyond capacity")
  `IBHQ_ASSERT_IMP(a_fail_zero, out_valid_o && !ok_o, (out_id_o == '0) && (out_priority_o == '0), "failed result not zero")

endmodule
`default_nettype wire
